// ----- hdl/pal_pkg.sv -----
// Package for the positional array list: constants, action codes, beat and control types.
`timescale 1ns / 1ps
`default_nettype none
package pal_pkg;

    localparam int LIST_DEPTH = 64;
    localparam int ELEM_W     = 32;
    localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = 7;
    localparam int ACT_W      = 3;
    localparam int DATA_W     = 32;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(64);
    localparam logic [CNT_W-1:0] CAP_MAX   = CNT_W'(LIST_DEPTH);

    localparam logic [ACT_W-1:0] ACT_READ   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_WRITE  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_INSERT = 3'd2;
    localparam logic [ACT_W-1:0] ACT_APPEND = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DELETE = 3'd4;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd5;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [CNT_W-1:0]  position;
        logic [DATA_W-1:0] value;
    } in_beat_t;

    typedef struct packed {
        logic              ok;
        logic [DATA_W-1:0] read_data;
        logic [CNT_W-1:0]  count;
        logic              empty_res;
    } out_beat_t;

    typedef struct packed {
        logic load;      // latch the input beat
        logic eval;      // check the position, set up the index
        logic rd_pos;    // read the addressed slot
        logic wr_pos;    // overwrite the addressed slot
        logic sh_rd;     // shift loop: read source slot
        logic sh_wr;     // shift loop: write destination slot, step index
        logic ins_tail;  // write the new element at the insert slot
        logic rd_cap;    // capture read data
        logic commit;    // update length, load the result register
    } ctl_cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic             ok_now;
        logic             more;
    } dp_stat_t;

endpackage
`default_nettype wire

// ----- hdl/pal_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module pal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                    aclk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- hdl/pal_dp.sv -----
// Datapath: operand registers, length and capacity, slot RAM, shift index and result register.
`timescale 1ns / 1ps
`default_nettype none
module pal_dp (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_we,
    input  wire logic [pal_pkg::CNT_W-1:0] cfg_wdata,
    input  wire pal_pkg::in_beat_t         s_data,
    input  wire pal_pkg::ctl_cmd_t         cmd,
    output pal_pkg::dp_stat_t              stat,
    output pal_pkg::out_beat_t             m_data
);
    import pal_pkg::*;

    logic [ACT_W-1:0]  act_reg;
    logic [CNT_W-1:0]  pos_reg;
    logic [ELEM_W-1:0] val_reg;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]  cap_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [ELEM_W-1:0] rd_reg;
    logic              ok_reg;
    out_beat_t         out_reg;

    logic [CNT_W-1:0]  cap_eff;
    logic              is_ins;
    logic [CNT_W-1:0]  ins_pos;
    logic              pos_in_range;
    logic              ins_in_range;
    logic              ok_now;

    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [ELEM_W-1:0] ram_wdata, ram_q;
    logic [CNT_W-1:0]  pos_m1, ins_m1, idx_m1;

    assign cap_eff      = (cap_reg > CAP_MAX) ? CAP_MAX : cap_reg;
    assign is_ins       = (act_reg == ACT_INSERT) || (act_reg == ACT_APPEND);
    assign ins_pos      = (act_reg == ACT_APPEND) ? fill_reg + CNT_W'(1) : pos_reg;
    assign pos_in_range = (pos_reg != '0) && (pos_reg <= fill_reg);
    assign ins_in_range = (ins_pos != '0) && (ins_pos <= fill_reg + CNT_W'(1))
                          && (fill_reg < cap_eff);

    always_comb begin
        case (act_reg)
            ACT_READ, ACT_WRITE, ACT_DELETE: ok_now = pos_in_range;
            ACT_INSERT, ACT_APPEND:          ok_now = ins_in_range;
            ACT_CLEAR:                       ok_now = 1'b1;
            default:                         ok_now = 1'b0;
        endcase
    end

    assign stat.act    = act_reg;
    assign stat.ok_now = ok_now;
    assign stat.more   = is_ins ? (idx_reg >= ins_pos) : (idx_reg < fill_reg);

    assign pos_m1 = pos_reg - CNT_W'(1);
    assign ins_m1 = ins_pos - CNT_W'(1);
    assign idx_m1 = idx_reg - CNT_W'(1);

    assign ram_re    = cmd.rd_pos | cmd.sh_rd;
    assign ram_raddr = cmd.rd_pos ? pos_m1[ADDR_W-1:0]
                     : (is_ins ? idx_m1[ADDR_W-1:0] : idx_reg[ADDR_W-1:0]);
    assign ram_we    = cmd.wr_pos | cmd.sh_wr | cmd.ins_tail;
    assign ram_wdata = cmd.sh_wr ? ram_q : val_reg;

    always_comb begin
        if (cmd.sh_wr) begin
            ram_waddr = is_ins ? idx_reg[ADDR_W-1:0] : idx_m1[ADDR_W-1:0];
        end else if (cmd.ins_tail) begin
            ram_waddr = ins_m1[ADDR_W-1:0];
        end else begin
            ram_waddr = pos_m1[ADDR_W-1:0];
        end
    end

    pal_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (LIST_DEPTH)
    ) u_slots (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    always_comb begin
        fill_next = fill_reg;
        if (cmd.commit && ok_reg) begin
            case (act_reg)
                ACT_INSERT, ACT_APPEND: fill_next = fill_reg + CNT_W'(1);
                ACT_DELETE:             fill_next = fill_reg - CNT_W'(1);
                ACT_CLEAR:              fill_next = '0;
                default:                fill_next = fill_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg  <= CAP_RESET;
            fill_reg <= '0;
        end else begin
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg <= s_data.action;
            pos_reg <= s_data.position;
            val_reg <= s_data.value[ELEM_W-1:0];
        end
        if (cmd.eval) begin
            ok_reg  <= ok_now;
            rd_reg  <= '0;
            idx_reg <= is_ins ? fill_reg : pos_reg;
        end
        if (cmd.sh_wr) begin
            idx_reg <= is_ins ? idx_m1 : idx_reg + CNT_W'(1);
        end
        if (cmd.rd_cap) begin
            rd_reg <= ram_q;
        end
        if (cmd.commit) begin
            out_reg.ok        <= ok_reg;
            out_reg.read_data <= DATA_W'(rd_reg);
            out_reg.count     <= fill_next;
            out_reg.empty_res <= (fill_next == '0);
        end
    end

    assign m_data = out_reg;

endmodule
`default_nettype wire

// ----- hdl/pal_ctrl.sv -----
// Controller: sequences each operation and owns the handshake flags.
`timescale 1ns / 1ps
`default_nettype none
module pal_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    input  wire pal_pkg::dp_stat_t stat,
    output pal_pkg::ctl_cmd_t      cmd
);
    import pal_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_SH_RD,
        S_SH_WR,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   is_ins, is_shift;

    assign is_ins   = (stat.act == ACT_INSERT) || (stat.act == ACT_APPEND);
    assign is_shift = is_ins || (stat.act == ACT_DELETE);
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.eval   = 1'b1;
                state_next = S_FINISH;
                if (stat.ok_now) begin
                    if (stat.act == ACT_READ) begin
                        cmd.rd_pos = 1'b1;
                        state_next = S_RDWAIT;
                    end else if (stat.act == ACT_WRITE) begin
                        cmd.wr_pos = 1'b1;
                    end else if (is_shift) begin
                        state_next = S_SH_RD;
                    end
                end
            end
            S_RDWAIT: begin
                cmd.rd_cap = 1'b1;
                state_next = S_FINISH;
            end
            S_SH_RD: begin
                if (stat.more) begin
                    cmd.sh_rd  = 1'b1;
                    state_next = S_SH_WR;
                end else begin
                    cmd.ins_tail = is_ins;
                    state_next   = S_FINISH;
                end
            end
            S_SH_WR: begin
                cmd.sh_wr  = 1'b1;
                state_next = S_SH_RD;
            end
            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/positional_array_list.sv -----
// Top level of the positional array list: controller, datapath and checks.
//
//  channel   ports                    beat
//  input     s_valid/s_ready/s_data   action, position, value
//  result    m_valid/m_ready/m_data   ok, read_data, count, empty_res
//  config    cfg_we/cfg_wdata         capacity, no handshake
//
// Write, clear and rejected items pass from S_EXEC straight to S_FINISH; a read
// adds S_RDWAIT; insert/append/delete add a slot read state then a slot write
// state per element moved (registered-read slot RAM).
// Synchronous active-low reset empties the list and sets capacity to 64.
// A finished result waits in the output register; the next beat is taken
// meanwhile and holds in its last cycle until the result is taken.
`timescale 1ns / 1ps
`default_nettype none
module positional_array_list (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_we,
    input  wire logic [pal_pkg::CNT_W-1:0] cfg_wdata,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire pal_pkg::in_beat_t         s_data,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output pal_pkg::out_beat_t             m_data
);
    import pal_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;

    pal_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    pal_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_data    (m_data)
    );

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while an item was in progress");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.count <= CAP_MAX))
        else $error("length beyond storage depth");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.empty_res == (m_data.count == '0)))
        else $error("empty flag disagrees with length");

    a_fail_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.ok) |-> (m_data.read_data == '0))
        else $error("read data on a rejected beat");

endmodule
`default_nettype wire

// ----- tb/sv/positional_array_list_checker.sv -----
// Checker for the positional array list: predicts every result beat and compares it.
`timescale 1ns / 1ps
module positional_array_list_checker (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_we,
    input  wire logic [pal_pkg::CNT_W-1:0] cfg_wdata,
    input  wire logic                      s_valid,
    input  wire logic                      s_ready,
    input  wire pal_pkg::in_beat_t         s_data,
    input  wire logic                      m_valid,
    input  wire logic                      m_ready,
    input  wire pal_pkg::out_beat_t        m_data,
    input  wire logic                      run_done,
    output int unsigned                    fail_count,
    output int unsigned                    results_seen,
    output int unsigned                    outstanding,
    output logic [pal_pkg::CNT_W-1:0]      list_len
);
    import pal_pkg::*;

    logic [ELEM_W-1:0] cells [LIST_DEPTH];
    logic [CNT_W-1:0]  cap_reg;
    int                fill_now;
    bit                end_checked;
    out_beat_t         expected_q [$];

    task automatic flag_error(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] got,
                               input logic [DATA_W-1:0] want);
        if (got !== want)
            flag_error($sformatf("result %0d field %s: got %0h, want %0h",
                                 results_seen, name, got, want));
    endtask

    // Applies one list operation to the shadow list and returns its result beat.
    function automatic out_beat_t apply_list_op(input in_beat_t op);
        out_beat_t res;
        int        len;
        int        pos;
        int        lim;
        int        j;
        res = '0;
        len = fill_now;
        pos = op.position;
        lim = (cap_reg > CAP_MAX) ? int'(CAP_MAX) : int'(cap_reg);
        if (op.action == ACT_APPEND)
            pos = len + 1;
        case (op.action)
            ACT_READ: begin
                if (pos != 0 && pos <= len) begin
                    res.read_data = cells[pos-1];
                    res.ok = 1'b1;
                end
            end
            ACT_WRITE: begin
                if (pos != 0 && pos <= len) begin
                    cells[pos-1] = op.value[ELEM_W-1:0];
                    res.ok = 1'b1;
                end
            end
            ACT_INSERT, ACT_APPEND: begin
                if (pos != 0 && pos <= len + 1 && len < lim) begin
                    for (j = len; j >= pos; j--)
                        cells[j] = cells[j-1];
                    cells[pos-1] = op.value[ELEM_W-1:0];
                    len++;
                    res.ok = 1'b1;
                end
            end
            ACT_DELETE: begin
                if (pos != 0 && pos <= len) begin
                    for (j = pos; j < len; j++)
                        cells[j-1] = cells[j];
                    len--;
                    res.ok = 1'b1;
                end
            end
            ACT_CLEAR: begin
                len = 0;
                res.ok = 1'b1;
            end
            default: ;
        endcase
        fill_now = len;
        res.count = CNT_W'(len);
        res.empty_res = (len == 0);
        return res;
    endfunction

    always @(posedge aclk) begin
        out_beat_t want;
        if (!aresetn) begin
            fill_now = 0;
            cap_reg = CAP_RESET;
            expected_q.delete();
        end else begin
            if (cfg_we)
                cap_reg = cfg_wdata;
            if (s_valid && s_ready)
                expected_q.push_back(apply_list_op(s_data));
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    flag_error("result beat with nothing expected");
                end else begin
                    want = expected_q.pop_front();
                    check_field("ok", DATA_W'(m_data.ok), DATA_W'(want.ok));
                    check_field("read_data", m_data.read_data, want.read_data);
                    check_field("count", DATA_W'(m_data.count), DATA_W'(want.count));
                    check_field("empty_res", DATA_W'(m_data.empty_res),
                                DATA_W'(want.empty_res));
                    results_seen++;
                end
            end
            if (run_done && !end_checked) begin
                end_checked = 1'b1;
                if (expected_q.size() != 0)
                    flag_error($sformatf("%0d expected result beats never arrived",
                                         expected_q.size()));
            end
        end
        outstanding <= expected_q.size();
        list_len <= CNT_W'(fill_now);
    end

endmodule

// ----- tb/sv/positional_array_list_test.sv -----
// Testbench top for the positional array list: stimulus, capacity phases and verdict.
`timescale 1ns / 1ps
module positional_array_list_test;
    import pal_pkg::*;

    localparam logic [ACT_W-1:0] ACT_BAD_LO  = 3'd6;
    localparam logic [ACT_W-1:0] ACT_BAD_HI  = 3'd7;
    localparam int               PHASES      = 8;
    localparam int               PHASE_OPS   = 128;
    localparam int               HOLD_CYCLES = 300;
    localparam int               CYCLE_LIMIT = 1500000;

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_wdata;
    logic             s_valid;
    logic             s_ready;
    in_beat_t         s_data;
    logic             m_valid;
    logic             m_ready;
    out_beat_t        m_data;
    logic             run_done;

    int unsigned      fail_count;
    int unsigned      results_seen;
    int unsigned      outstanding;
    logic [CNT_W-1:0] list_len;

    logic             quiet;
    logic             grow;
    logic             hold_tgl;
    logic             hold_seen;
    int unsigned      cycle_count;
    int unsigned      ops_sent;
    int unsigned      cap_writes;
    int unsigned      peak_len;

    always #6 aclk = ~aclk;

    positional_array_list dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    positional_array_list_checker checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .run_done     (run_done),
        .fail_count   (fail_count),
        .results_seen (results_seen),
        .outstanding  (outstanding),
        .list_len     (list_len)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, outstanding);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int unsigned pick_stall();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 4);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [ACT_W-1:0] pick_action(input logic more_inserts);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (more_inserts) begin
            if (r < 15) return ACT_READ;
            if (r < 25) return ACT_WRITE;
            if (r < 55) return ACT_INSERT;
            if (r < 85) return ACT_APPEND;
            if (r < 97) return ACT_DELETE;
            if (r < 98) return ACT_CLEAR;
        end else begin
            if (r < 20) return ACT_READ;
            if (r < 35) return ACT_WRITE;
            if (r < 55) return ACT_INSERT;
            if (r < 75) return ACT_APPEND;
            if (r < 95) return ACT_DELETE;
            if (r < 97) return ACT_CLEAR;
        end
        return r[0] ? ACT_BAD_HI : ACT_BAD_LO;
    endfunction

    function automatic logic [CNT_W-1:0] pick_position(input int len);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return CNT_W'($urandom_range(1, len + 1));
        if (r < 78)
            return '0;
        if (r < 88)
            return CNT_W'(len + 1 + $urandom_range(0, 2));
        return CNT_W'($urandom_range(0, 127));
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 16)
            return '1;
        return $urandom;
    endfunction

    task automatic send_op(input logic [ACT_W-1:0] act, input logic [CNT_W-1:0] pos,
                           input logic [DATA_W-1:0] val);
        int unsigned gap;
        s_data <= '{action: act, position: pos, value: val};
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        ops_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        if (list_len > peak_len)
            peak_len = list_len;
    endtask

    // Stop offering beats and wait until every result has been taken.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [CNT_W-1:0] cap);
        drain();
        cfg_wdata <= cap;
        cfg_we <= 1'b1;
        @(posedge aclk);
        cfg_we <= 1'b0;
        cap_writes++;
    endtask

    // Result side: random stalls, quiet stretches and a long hold on request.
    initial begin
        m_ready = 1'b0;
        hold_seen = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_tgl != hold_seen) begin
                hold_seen = hold_tgl;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (quiet) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                if ($urandom_range(0, 2) == 0) begin
                    m_ready <= 1'b0;
                    repeat (pick_stall()) @(posedge aclk);
                end
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
    end

    initial begin
        logic [CNT_W-1:0] phase_cap [PHASES];
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_data = '0;
        run_done = 1'b0;
        quiet = 1'b0;
        grow = 1'b0;
        hold_tgl = 1'b0;
        cycle_count = 0;
        ops_sent = 0;
        cap_writes = 0;
        peak_len = 0;
        phase_cap = '{7'd127, 7'd1, 7'd0, 7'd64, 7'd16, 7'd3, 7'd64,
                      CNT_W'($urandom_range(0, 127))};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty list, position limits, every action, unknown codes
        send_op(ACT_READ, 7'd1, 32'h1);
        send_op(ACT_DELETE, 7'd1, 32'h0);
        send_op(ACT_INSERT, 7'd2, 32'h2);
        send_op(ACT_INSERT, 7'd0, 32'h3);
        send_op(ACT_APPEND, 7'd0, 32'hFFFF_FFFF);
        send_op(ACT_INSERT, 7'd1, 32'h0);
        send_op(ACT_INSERT, 7'd3, 32'hA5A5_A5A5);
        send_op(ACT_READ, 7'd0, 32'h0);
        send_op(ACT_READ, 7'd3, 32'h0);
        send_op(ACT_READ, 7'd4, 32'h0);
        send_op(ACT_WRITE, 7'd2, 32'h5A5A_5A5A);
        send_op(ACT_WRITE, 7'd127, 32'h1234_5678);
        send_op(ACT_DELETE, 7'd1, 32'h0);
        send_op(ACT_READ, 7'd1, 32'h0);
        send_op(ACT_BAD_LO, 7'd1, 32'h0);
        send_op(ACT_BAD_HI, 7'd1, 32'hFFFF_FFFF);
        send_op(ACT_CLEAR, 7'd127, 32'h0);
        send_op(ACT_APPEND, 7'd0, 32'h11);
        send_op(ACT_APPEND, 7'd0, 32'h22);
        send_op(ACT_APPEND, 7'd0, 32'h33);
        // capacity dropped below the length: held elements stay, growth refused
        write_capacity(7'd2);
        send_op(ACT_APPEND, 7'd0, 32'h44);
        send_op(ACT_INSERT, 7'd1, 32'h45);
        send_op(ACT_DELETE, 7'd3, 32'h0);
        send_op(ACT_APPEND, 7'd0, 32'h46);
        send_op(ACT_DELETE, 7'd1, 32'h0);
        send_op(ACT_APPEND, 7'd0, 32'h55);
        write_capacity(7'd0);
        send_op(ACT_APPEND, 7'd0, 32'h66);

        for (int ph = 0; ph < PHASES; ph++) begin
            write_capacity(phase_cap[ph]);
            grow = (ph == 0 || ph == 3 || ph == 6);
            quiet = (ph == 4);
            for (int n = 0; n < PHASE_OPS; n++) begin
                if ((ph == 1 && n == 50) || (ph == 3 && n == 40))
                    hold_tgl = ~hold_tgl;
                if (ph == 6 && n == 64)
                    drain();
                send_op(pick_action(grow), pick_position(int'(list_len)), pick_value());
            end
        end

        drain();
        repeat (30) @(posedge aclk);
        run_done <= 1'b1;
        repeat (2) @(posedge aclk);
        $display("covered %0d list operations over %0d capacity writes, peak length %0d",
                 ops_sent, cap_writes, peak_len);
        $display("checked %0d result beats in %0d cycles", results_seen, cycle_count);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
